[rtl/tsp_pkg.sv]
package tsp_pkg;

    localparam int SCREEN_WIDTH  = 800;
    localparam int SCREEN_HEIGHT = 480;

    localparam logic [11:0] ADC_FULL = 12'd4095;
    localparam logic [11:0] X_LO     = 12'd280;
    localparam logic [11:0] Y_LO     = 12'd500;
    localparam int          X_SPAN   = 3503;
    localparam int          Y_SPAN   = 3020;

    localparam logic [2:0] REG_PLATE = 3'd0;
    localparam logic [2:0] REG_LIMIT = 3'd1;
    localparam logic [2:0] REG_XX    = 3'd2;
    localparam logic [2:0] REG_XY    = 3'd3;
    localparam logic [2:0] REG_XO    = 3'd4;
    localparam logic [2:0] REG_YX    = 3'd5;
    localparam logic [2:0] REG_YY    = 3'd6;
    localparam logic [2:0] REG_YO    = 3'd7;

    typedef struct packed {
        logic        pen_down;
        logic [11:0] raw_x;
        logic [11:0] raw_y;
        logic [11:0] raw_z1;
        logic [11:0] raw_z2;
        logic        panel_flipped;
    } sample_t;

    typedef struct packed {
        logic               touching;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
    } point_t;

    // serial unit operations
    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV
    } op_t;

    typedef struct packed {
        logic        start;
        op_t         op;
        logic [31:0] a;
        logic [31:0] b;
    } ser_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] result;
    } ser_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RT_MUL1,
        ST_RT_MUL2,
        ST_RT_DIV,
        ST_RT_CHECK,
        ST_SX,
        ST_SY,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_M4,
        ST_FINISH,
        ST_OUT
    } state_t;

endpackage

[rtl/tsp_serial_unit.sv]
// Shared shift-and-add multiplier (low 32 bits) and restoring divider,
// one bit per cycle while busy.
module tsp_serial_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  tsp_pkg::ser_req_t req,
    output tsp_pkg::ser_rsp_t rsp
);
    import tsp_pkg::*;

    logic        busy_reg, busy_next;
    logic [4:0]  cnt_reg, cnt_next;
    op_t         op_reg, op_next;
    logic [31:0] a_reg, a_next;
    logic [31:0] b_reg, b_next;
    logic [31:0] acc_reg, acc_next;
    logic        done_reg, done_next;
    logic [32:0] trial;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk) begin
        op_reg  <= op_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    // divider: acc is partial remainder, a shifts dividend out / quotient in
    assign trial = {acc_reg, a_reg[31]} - {1'b0, b_reg};

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        done_next = 1'b0;
        if (!busy_reg) begin
            if (req.start) begin
                busy_next = 1'b1;
                cnt_next  = '0;
                op_next   = req.op;
                a_next    = req.a;
                b_next    = req.b;
                acc_next  = '0;
            end
        end else begin
            if (op_reg == OP_MUL) begin
                if (b_reg[0])
                    acc_next = acc_reg + a_reg;
                a_next = {a_reg[30:0], 1'b0};
                b_next = {1'b0, b_reg[31:1]};
            end else begin
                if (!trial[32]) begin
                    acc_next = trial[31:0];
                    a_next   = {a_reg[30:0], 1'b1};
                end else begin
                    acc_next = {acc_reg[30:0], a_reg[31]};
                    a_next   = {a_reg[30:0], 1'b0};
                end
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = (op_reg == OP_MUL) ? acc_reg : a_reg;

endmodule

[rtl/touch_sample_to_screen_point_core.sv]
// channel  | dir | signals                      | beat
// sample   | in  | in_valid in_ready in_data    | one raw touch sample
// point    | out | out_valid out_ready out_data | one point or release
// cfg      | in  | cfg_we cfg_index cfg_data    | one register write
// A pen-up beat is taken in idle and offers its release the next cycle.
// A pen-down sample runs through one shared bit-serial multiply/divide unit:
// each operation is a start, 32 bit steps and a result; 3 operations for
// resistance, 2 for scaling, 4 for the calibration products. A sample
// rejected on pressure stops after the resistance operations.
// Reset restores the registers and clears the last point. A waiting
// result holds the unit until out_ready; in_ready is low while busy.
module touch_sample_to_screen_point_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  tsp_pkg::sample_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output tsp_pkg::point_t  out_data,
    input  logic             cfg_we,
    input  logic [2:0]       cfg_index,
    input  logic [31:0]      cfg_data
);
    import tsp_pkg::*;

    state_t state_reg, state_next;
    logic [15:0] plate_reg, limit_reg;
    logic [31:0] cxx_reg, cxy_reg, cxo_reg, cyx_reg, cyy_reg, cyo_reg;
    logic [31:0] last_x_reg, last_x_next, last_y_reg, last_y_next;
    sample_t     s_reg, s_next;
    logic [31:0] t_reg, t_next;
    logic [31:0] mx_reg, mx_next, my_reg, my_next;
    logic [31:0] px_reg, px_next, py_reg, py_next;
    point_t      o_reg, o_next;
    ser_req_t    req;
    ser_rsp_t    rsp;
    logic [11:0] x_eff;
    logic [12:0] ox, oy;
    logic [31:0] qx, qy, fx, fy;

    tsp_serial_unit u_ser (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            plate_reg <= 16'd1;
            limit_reg <= 16'd4095;
            cxx_reg   <= 32'd65536;
            cxy_reg   <= '0;
            cxo_reg   <= '0;
            cyx_reg   <= '0;
            cyy_reg   <= 32'd65536;
            cyo_reg   <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_PLATE: plate_reg <= cfg_data[15:0];
                REG_LIMIT: limit_reg <= cfg_data[15:0];
                REG_XX:    cxx_reg   <= cfg_data;
                REG_XY:    cxy_reg   <= cfg_data;
                REG_XO:    cxo_reg   <= cfg_data;
                REG_YX:    cyx_reg   <= cfg_data;
                REG_YY:    cyy_reg   <= cfg_data;
                REG_YO:    cyo_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg  <= ST_IDLE;
            last_x_reg <= '0;
            last_y_reg <= '0;
        end else begin
            state_reg  <= state_next;
            last_x_reg <= last_x_next;
            last_y_reg <= last_y_next;
        end
    end

    always_ff @(posedge clk) begin
        s_reg  <= s_next;
        t_reg  <= t_next;
        mx_reg <= mx_next;
        my_reg <= my_next;
        px_reg <= px_next;
        py_reg <= py_next;
        o_reg  <= o_next;
    end

    assign x_eff = (s_reg.raw_x == ADC_FULL) ? 12'd0 : s_reg.raw_x;
    assign ox = ({1'b0, x_eff} < {1'b0, X_LO}) ? 13'd1 : {1'b0, x_eff} - {1'b0, X_LO};
    assign oy = ({1'b0, s_reg.raw_y} < {1'b0, Y_LO}) ? 13'd1
              : {1'b0, s_reg.raw_y} - {1'b0, Y_LO};

    // signed divide by 65536, truncating toward zero
    assign qx = px_reg[31] ? 32'(($signed(px_reg) + 32'sd65535) >>> 16)
                           : {16'd0, px_reg[31:16]};
    assign qy = py_reg[31] ? 32'(($signed(py_reg) + 32'sd65535) >>> 16)
                           : {16'd0, py_reg[31:16]};
    assign fx = s_reg.panel_flipped ? 32'(SCREEN_WIDTH) - qx : qx;
    assign fy = s_reg.panel_flipped ? 32'(SCREEN_HEIGHT) - qy : qy;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = in_data.pen_down ? ST_RT_MUL1 : ST_OUT;
            ST_RT_MUL1:  if (rsp.done) state_next = ST_RT_MUL2;
            ST_RT_MUL2:  if (rsp.done) state_next = ST_RT_DIV;
            ST_RT_DIV:   if (rsp.done) state_next = ST_RT_CHECK;
            ST_RT_CHECK: state_next = (t_reg > {16'd0, limit_reg}) ? ST_IDLE : ST_SX;
            ST_SX:       if (rsp.done) state_next = ST_SY;
            ST_SY:       if (rsp.done) state_next = ST_M1;
            ST_M1:       if (rsp.done) state_next = ST_M2;
            ST_M2:       if (rsp.done) state_next = ST_M3;
            ST_M3:       if (rsp.done) state_next = ST_M4;
            ST_M4:       if (rsp.done) state_next = ST_FINISH;
            ST_FINISH:
                state_next = (fx != last_x_reg || fy != last_y_reg) ? ST_OUT : ST_IDLE;
            ST_OUT:      if (out_ready) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_next      = s_reg;
        t_next      = t_reg;
        mx_next     = mx_reg;
        my_next     = my_reg;
        px_next     = px_reg;
        py_next     = py_reg;
        o_next      = o_reg;
        last_x_next = last_x_reg;
        last_y_next = last_y_reg;
        req.start   = 1'b0;
        req.op      = OP_MUL;
        req.a       = '0;
        req.b       = '0;
        in_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    s_next = in_data;
                    o_next = '0;
                end
            end
            ST_RT_MUL1: begin
                req.start = 1'b1;
                req.a = {20'd0, s_reg.raw_z2} - {20'd0, s_reg.raw_z1};
                req.b = {20'd0, x_eff};
                if (rsp.done) t_next = rsp.result;
            end
            ST_RT_MUL2: begin
                req.start = 1'b1;
                req.a = t_reg;
                req.b = {16'd0, plate_reg};
                if (rsp.done) t_next = rsp.result;
            end
            ST_RT_DIV: begin
                req.start = 1'b1;
                req.op = OP_DIV;
                req.a = t_reg;
                req.b = {20'd0, s_reg.raw_z1};
                if (rsp.done) begin
                    if (x_eff == 12'd0 || s_reg.raw_z1 == 12'd0)
                        t_next = '0;
                    else
                        t_next = (rsp.result + 32'd2047) >> 12;
                end
            end
            ST_RT_CHECK: begin
                if (t_reg > {16'd0, limit_reg}) begin
                    last_x_next = '0;
                    last_y_next = '0;
                end
                t_next = 32'(SCREEN_WIDTH) * {19'd0, ox};
            end
            ST_SX: begin
                req.start = 1'b1;
                req.op = OP_DIV;
                req.a = t_reg;
                req.b = 32'(X_SPAN);
                if (rsp.done) begin
                    mx_next = 32'(SCREEN_WIDTH) - rsp.result;
                    t_next  = 32'(SCREEN_HEIGHT) * {19'd0, oy};
                end
            end
            ST_SY: begin
                req.start = 1'b1;
                req.op = OP_DIV;
                req.a = t_reg;
                req.b = 32'(Y_SPAN);
                if (rsp.done) my_next = 32'(SCREEN_HEIGHT) - rsp.result;
            end
            ST_M1: begin
                req.start = 1'b1;
                req.a = cxx_reg;
                req.b = mx_reg;
                if (rsp.done) px_next = cxo_reg + rsp.result;
            end
            ST_M2: begin
                req.start = 1'b1;
                req.a = cxy_reg;
                req.b = my_reg;
                if (rsp.done) px_next = px_reg + rsp.result;
            end
            ST_M3: begin
                req.start = 1'b1;
                req.a = cyx_reg;
                req.b = mx_reg;
                if (rsp.done) py_next = cyo_reg + rsp.result;
            end
            ST_M4: begin
                req.start = 1'b1;
                req.a = cyy_reg;
                req.b = my_reg;
                if (rsp.done) py_next = py_reg + rsp.result;
            end
            ST_FINISH: begin
                last_x_next = fx;
                last_y_next = fy;
                o_next.touching = 1'b1;
                o_next.point_x  = fx;
                o_next.point_y  = fy;
            end
            default: ;
        endcase
        // unit is idle while done is high; hold start off then
        if (rsp.done) req.start = 1'b0;
    end

    assign out_valid = (state_reg == ST_OUT);
    assign out_data  = o_reg;

endmodule

[rtl/tsp_checker.sv]
module tsp_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input tsp_pkg::sample_t in_data,
    input logic             out_valid,
    input logic             out_ready,
    input tsp_pkg::point_t  out_data
);
    import tsp_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while result pending");

    a_release_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.touching |-> out_data.point_x == 0 && out_data.point_y == 0)
        else $error("release carries a point");

    a_pen_up_fast: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !in_data.pen_down |=> out_valid && !out_data.touching)
        else $error("pen-up did not give a release");

endmodule

bind touch_sample_to_screen_point_core tsp_checker u_tsp_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
);
